>>> hw/rtl/apsp_pkg.sv
// Shared types, constants and the sequencer microprogram of the all-pairs shortest path unit.
package apsp_pkg;

  localparam int APSP_MAX_NODES = 32;

  localparam int IDX_W       = 5;
  localparam int WEIGHT_W    = 9;
  localparam int DIST_W      = 13;
  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [DIST_W-1:0] DIST_MAX = 13'h1FFF;

  localparam logic [5:0] NODE_COUNT_RST = 6'd32;
  localparam logic [7:0] MAX_WEIGHT_RST = 8'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WEIGHT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    COND_GOTO,
    COND_DISPATCH,
    COND_WAIT_OUT,
    COND_LOOP_J,
    COND_LOOP_I,
    COND_LOOP_K
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE   = 3'd0;
  localparam step_t ST_RD_OUT = 3'd1;
  localparam step_t ST_IK_RD  = 3'd2;
  localparam step_t ST_IK_CAP = 3'd3;
  localparam step_t ST_J_RD   = 3'd4;
  localparam step_t ST_J_REL  = 3'd5;
  localparam step_t ST_I_END  = 3'd6;
  localparam step_t ST_K_END  = 3'd7;

  // one microprogram word
  typedef struct packed {
    cond_t cond;
    step_t tgt;
    step_t alt;
    logic  rd_ik;
    logic  rd_kjij;
    logic  cap_dik;
    logic  relax;
  } uword_t;

  // sequencer to datapath control
  typedef struct packed {
    logic op_load;
    logic op_read;
    logic rd_ik;
    logic rd_kjij;
    logic cap_dik;
    logic relax;
    logic out_ld;
  } ctrl_t;

  // tgt is the taken branch, alt the loop exit (or the run entry for dispatch)
  function automatic uword_t useq_rom(input step_t step);
    uword_t w;
    w.cond    = COND_GOTO;
    w.tgt     = ST_IDLE;
    w.alt     = ST_IDLE;
    w.rd_ik   = 1'b0;
    w.rd_kjij = 1'b0;
    w.cap_dik = 1'b0;
    w.relax   = 1'b0;
    case (step)
      ST_IDLE: begin
        w.cond = COND_DISPATCH;
        w.tgt  = ST_RD_OUT;
        w.alt  = ST_IK_RD;
      end
      ST_RD_OUT: begin
        w.cond = COND_WAIT_OUT;
        w.tgt  = ST_IDLE;
      end
      ST_IK_RD: begin
        w.tgt   = ST_IK_CAP;
        w.rd_ik = 1'b1;
      end
      ST_IK_CAP: begin
        w.tgt     = ST_J_RD;
        w.cap_dik = 1'b1;
      end
      ST_J_RD: begin
        w.tgt     = ST_J_REL;
        w.rd_kjij = 1'b1;
      end
      ST_J_REL: begin
        w.cond  = COND_LOOP_J;
        w.tgt   = ST_J_RD;
        w.alt   = ST_I_END;
        w.relax = 1'b1;
      end
      ST_I_END: begin
        w.cond = COND_LOOP_I;
        w.tgt  = ST_IK_RD;
        w.alt  = ST_K_END;
      end
      ST_K_END: begin
        w.cond = COND_LOOP_K;
        w.tgt  = ST_IK_RD;
        w.alt  = ST_IDLE;
      end
      default: begin
        w.cond = COND_GOTO;
        w.tgt  = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/apsp_useq.sv
// Microcoded sequencer: step counter, program table, loop counters and request dispatch.
module apsp_useq import apsp_pkg::*; #(
  parameter int MAX_NODES = APSP_MAX_NODES,
  localparam int NB = $clog2(MAX_NODES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  input  logic              out_busy,
  input  logic [NB-1:0]     last_idx,
  output logic              in_ready,
  output ctrl_t             ctrl,
  output logic [NB-1:0]     i_idx,
  output logic [NB-1:0]     j_idx,
  output logic [NB-1:0]     k_idx
);

  step_t         upc_r, upc_nxt;
  logic [NB-1:0] i_r, i_nxt;
  logic [NB-1:0] j_r, j_nxt;
  logic [NB-1:0] k_r, k_nxt;
  uword_t        uw;
  logic          accept;

  assign uw    = useq_rom(upc_r);
  assign i_idx = i_r;
  assign j_idx = j_r;
  assign k_idx = k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_IDLE;
      i_r   <= '0;
      j_r   <= '0;
      k_r   <= '0;
    end else begin
      upc_r <= upc_nxt;
      i_r   <= i_nxt;
      j_r   <= j_nxt;
      k_r   <= k_nxt;
    end
  end

  always_comb begin
    upc_nxt      = uw.tgt;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    in_ready     = (uw.cond == COND_DISPATCH);
    accept       = in_ready & in_valid;
    ctrl.op_load = 1'b0;
    ctrl.op_read = 1'b0;
    ctrl.rd_ik   = uw.rd_ik;
    ctrl.rd_kjij = uw.rd_kjij;
    ctrl.cap_dik = uw.cap_dik;
    ctrl.relax   = uw.relax;
    ctrl.out_ld  = 1'b0;
    case (uw.cond)
      COND_GOTO: begin
        upc_nxt = uw.tgt;
      end
      COND_DISPATCH: begin
        upc_nxt = ST_IDLE;
        if (accept) begin
          case (kind_t'(in_kind))
            KIND_LOAD: ctrl.op_load = 1'b1;
            KIND_RUN:  upc_nxt = uw.alt;
            KIND_READ: begin
              ctrl.op_read = 1'b1;
              upc_nxt      = uw.tgt;
            end
            default:   upc_nxt = ST_IDLE;
          endcase
        end
      end
      COND_WAIT_OUT: begin
        if (out_busy) begin
          upc_nxt = upc_r;
        end else begin
          ctrl.out_ld = 1'b1;
        end
      end
      COND_LOOP_J: begin
        if (j_r == last_idx) begin
          j_nxt   = '0;
          upc_nxt = uw.alt;
        end else begin
          j_nxt = j_r + NB'(1);
        end
      end
      COND_LOOP_I: begin
        if (i_r == last_idx) begin
          i_nxt   = '0;
          upc_nxt = uw.alt;
        end else begin
          i_nxt = i_r + NB'(1);
        end
      end
      COND_LOOP_K: begin
        if (k_r == last_idx) begin
          k_nxt   = '0;
          upc_nxt = uw.alt;
        end else begin
          k_nxt = k_r + NB'(1);
        end
      end
      default: upc_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/apsp_dpath.sv
// Datapath: distance memory, relaxation add and compare, result register.
module apsp_dpath import apsp_pkg::*; #(
  parameter int MAX_NODES = APSP_MAX_NODES,
  localparam int NB = $clog2(MAX_NODES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_t                      ctrl,
  input  logic [NB-1:0]              i_idx,
  input  logic [NB-1:0]              j_idx,
  input  logic [NB-1:0]              k_idx,
  input  logic [IDX_W-1:0]           row,
  input  logic [IDX_W-1:0]           col,
  input  logic signed [WEIGHT_W-1:0] weight,
  input  logic [DIST_W-1:0]          noedge,
  input  logic                       out_tready,
  output logic                       out_busy,
  output logic                       out_valid,
  output logic [DIST_W-1:0]          out_distance
);

  localparam int AW    = 2 * NB;
  localparam int DEPTH = 1 << AW;

  logic [DIST_W-1:0] mem [DEPTH];

  logic [DIST_W-1:0] rda_r, rdb_r, dik_r, out_data_r;
  logic              rd_in_r;
  logic              out_valid_r;

  logic              in_range;
  logic [AW-1:0]     req_addr, wr_addr, rda_addr;
  logic [DIST_W:0]   via;
  logic              lt;
  logic [DIST_W-1:0] load_d, wr_data;
  logic              wr_en, rda_en;

  assign in_range = (32'(row) < MAX_NODES) && (32'(col) < MAX_NODES);
  assign req_addr = {NB'(row), NB'(col)};

  // d[i][k] + d[k][j] against d[i][j]; one bit wider so the sum cannot wrap
  assign via = {1'b0, dik_r} + {1'b0, rda_r};
  assign lt  = via < {1'b0, rdb_r};

  // sign bit set means no edge
  assign load_d = weight[WEIGHT_W-1] ? noedge : DIST_W'(weight[WEIGHT_W-2:0]);

  assign wr_en    = (ctrl.op_load & in_range) | (ctrl.relax & lt);
  assign wr_addr  = ctrl.op_load ? req_addr : {i_idx, j_idx};
  assign wr_data  = ctrl.op_load ? load_d : via[DIST_W-1:0];
  assign rda_en   = ctrl.op_read | ctrl.rd_ik | ctrl.rd_kjij;
  assign rda_addr = ctrl.op_read ? req_addr :
                    ctrl.rd_ik   ? {i_idx, k_idx} : {k_idx, j_idx};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rda_en) begin
      rda_r <= mem[rda_addr];
    end
    if (ctrl.rd_kjij) begin
      rdb_r <= mem[{i_idx, j_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap_dik) begin
      dik_r <= rda_r;
    end
    if (ctrl.op_read) begin
      rd_in_r <= in_range;
    end
    if (ctrl.out_ld) begin
      out_data_r <= rd_in_r ? rda_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_busy     = out_valid_r & ~out_tready;
  assign out_valid    = out_valid_r;
  assign out_distance = out_data_r;

endmodule

>>> hw/rtl/all_pairs_shortest_path_unit.sv
// Top level of the all-pairs shortest path unit: ports, configuration registers, assertions.
//
// Holds a MAX_NODES by MAX_NODES matrix of 13-bit distances in an on-chip memory with one
// write and two read ports, driven by a small microprogram. A load request writes one entry
// (a negative weight stores max_weight * n, saturated at 8191, where n is node_count limited
// to 1..MAX_NODES). A read request leaves its distance in the output register, stalling
// further requests while that register is still full. A run request relaxes the leading
// n by n block through one shared add-compare unit, taking no requests until it is done.
// The memory has no reset; entries hold nothing useful until loaded.
module all_pairs_shortest_path_unit import apsp_pkg::*; #(
  parameter int MAX_NODES = APSP_MAX_NODES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // row[4:0], col[9:5], weight[18:10], zeros
  input  logic [KIND_W-1:0]      in_tuser,    // kind[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // distance[12:0], zeros
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

  localparam int NB = $clog2(MAX_NODES);

  logic [5:0]                node_count_r;
  logic [7:0]                max_weight_r;
  logic [6:0]                nodes;
  logic [NB-1:0]             last_idx;
  logic [14:0]               prod;
  logic [DIST_W-1:0]         noedge;
  logic [IDX_W-1:0]          row, col;
  logic signed [WEIGHT_W-1:0] weight;
  logic [DIST_W-1:0]         distance;
  logic                      out_busy;
  ctrl_t                     ctrl;
  logic [NB-1:0]             i_idx, j_idx, k_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      max_weight_r <= MAX_WEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count_r <= cfg_wr_data[5:0];
        CFG_MAX_WEIGHT: max_weight_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (node_count_r == 6'd0) begin
      nodes = 7'd1;
    end else if (32'(node_count_r) > MAX_NODES) begin
      nodes = 7'(MAX_NODES);
    end else begin
      nodes = {1'b0, node_count_r};
    end
  end

  assign last_idx = NB'(nodes - 7'd1);
  assign prod     = 15'(max_weight_r) * 15'(nodes);
  assign noedge   = (prod > 15'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];

  assign row    = in_tdata[4:0];
  assign col    = in_tdata[9:5];
  assign weight = in_tdata[18:10];

  apsp_useq #(.MAX_NODES(MAX_NODES)) u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .out_busy (out_busy),
    .last_idx (last_idx),
    .in_ready (in_tready),
    .ctrl     (ctrl),
    .i_idx    (i_idx),
    .j_idx    (j_idx),
    .k_idx    (k_idx)
  );

  apsp_dpath #(.MAX_NODES(MAX_NODES)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .i_idx        (i_idx),
    .j_idx        (j_idx),
    .k_idx        (k_idx),
    .row          (row),
    .col          (col),
    .weight       (weight),
    .noedge       (noedge),
    .out_tready   (out_tready),
    .out_busy     (out_busy),
    .out_valid    (out_tvalid),
    .out_distance (distance)
  );

  assign out_tdata = OUT_TDATA_W'(distance);

  // a run request locks out further requests on the following cycle
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == KIND_RUN) |=> !in_tready)
    else $error("request taken right after a run request");

  // no request is taken while the closure loop relaxes entries
  a_relax_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.relax |-> !in_tready)
    else $error("request accepted during relaxation");

  // a loaded read result shows on the output the next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_ld |=> out_tvalid)
    else $error("read result lost");

  // the output register is only refilled when empty or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_ld |-> (!out_tvalid || out_tready))
    else $error("read result overwritten");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the all-pairs shortest path unit.
`timescale 1ns / 100ps

module testbench;
  import apsp_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_LIMIT = 10000;  // longest closure here (n=8) runs with no handshake
  localparam int LONG_HOLD = 300;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 60;
  localparam int NODES = APSP_MAX_NODES;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [WEIGHT_W-1:0] NO_EDGE_WEIGHT = 9'h1FF;  // -1

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  // shadow of the distance matrix and the registers
  logic [DIST_W-1:0] dist_table [NODES*NODES];
  bit entry_loaded [NODES*NODES];
  logic [5:0] model_node_count = NODE_COUNT_RST;
  logic [7:0] model_max_weight = MAX_WEIGHT_RST;
  logic [DIST_W-1:0] expected_distances [$];

  int error_count = 0;
  int cycle_count = 0;
  int idle_cycles = 0;
  int busy_until = 0;
  int hold_requests = 0;
  bit offering = 1'b0;
  int burst_left = 1;

  always #(CLK_PERIOD/2) clk = ~clk;

  all_pairs_shortest_path_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic int entry_of(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    return int'(row) * NODES + int'(col);
  endfunction

  function automatic int used_node_count();
    if (model_node_count == 0) return 1;
    if (model_node_count > NODES) return NODES;
    return int'(model_node_count);
  endfunction

  function automatic logic [DIST_W-1:0] no_edge_value();
    int d;
    d = int'(model_max_weight) * used_node_count();
    if (d > int'(DIST_MAX)) return DIST_MAX;
    return d[DIST_W-1:0];
  endfunction

  function automatic int run_cycles(input int n);
    return n * (n * (2 * n + 3) + 1);
  endfunction

  // k-i-j relaxation; d[i][k] cannot change while row i is swept through j
  function automatic void relax_all_pairs();
    int n, k, i, j, dik, via;
    n = used_node_count();
    for (k = 0; k < n; k++) begin
      for (i = 0; i < n; i++) begin
        dik = int'(dist_table[i*NODES+k]);
        for (j = 0; j < n; j++) begin
          via = dik + int'(dist_table[k*NODES+j]);
          if (via < int'(dist_table[i*NODES+j])) dist_table[i*NODES+j] = via[DIST_W-1:0];
        end
      end
    end
  endfunction

  function automatic void predict_request(input logic [KIND_W-1:0] kind,
                                          input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col,
                                          input logic [WEIGHT_W-1:0] weight);
    if (kind == KIND_LOAD) begin
      dist_table[entry_of(row, col)] = weight[WEIGHT_W-1] ? no_edge_value()
                                                          : {5'd0, weight[7:0]};
      entry_loaded[entry_of(row, col)] = 1'b1;
    end else if (kind == KIND_RUN) begin
      relax_all_pairs();
      busy_until = cycle_count + run_cycles(used_node_count()) + 32;
    end else if (kind == KIND_READ) begin
      expected_distances = {expected_distances, dist_table[entry_of(row, col)]};
    end
    if (kind != KIND_RUN && cycle_count + 16 > busy_until) busy_until = cycle_count + 16;
  endfunction

  task automatic idle_input();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [WEIGHT_W-1:0] weight);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {5'd0, weight, col, row};
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_request(kind, row, col, weight);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        idle_input();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait for outstanding reads and for any closure still in progress
  task automatic drain();
    idle_input();
    while (expected_distances.size() != 0) @(posedge clk);
    while (cycle_count < busy_until) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_config(input logic [5:0] nodes, input logic [7:0] weight_max);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_NODE_COUNT;
    cfg_wr_data <= {2'd0, nodes};
    @(posedge clk);
    cfg_index <= CFG_MAX_WEIGHT;
    cfg_wr_data <= weight_max;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_node_count = nodes;
    model_max_weight = weight_max;
    @(posedge clk);
  endtask

  function automatic logic [WEIGHT_W-1:0] random_weight();
    logic [WEIGHT_W-1:0] w;
    w = 9'($urandom_range(0, 30));
    case ($urandom_range(0, 9))
      0: w = NO_EDGE_WEIGHT;
      1: w = {1'b1, 8'($urandom_range(0, 255))};
      2: w = 9'd0;
      3: w = 9'd255;
      4: w = 9'($urandom_range(0, 255));
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input int span);
    logic [IDX_W-1:0] idx;
    if ($urandom_range(0, 3) != 0) idx = 5'($urandom_range(0, span - 1));
    else idx = 5'($urandom_range(0, NODES - 1));
    return idx;
  endfunction

  // every entry of the leading block must hold a distance before a closure
  task automatic fill_block(input int span);
    int r, c;
    for (r = 0; r < span; r++)
      for (c = 0; c < span; c++)
        if (!entry_loaded[r*NODES+c]) send_item(KIND_LOAD, 5'(r), 5'(c), random_weight());
  endtask

  task automatic send_read_of_loaded(input int span);
    logic [IDX_W-1:0] r, c;
    int tries;
    tries = 0;
    do begin
      r = pick_index(span);
      c = pick_index(span);
      tries++;
    end while (!entry_loaded[entry_of(r, c)] && tries < 16);
    if (!entry_loaded[entry_of(r, c)]) begin
      r = '0;
      c = '0;
    end
    send_item(KIND_READ, r, c, 9'($urandom));
  endtask

  task automatic send_run();
    fill_block(used_node_count());
    send_item(KIND_RUN, 5'($urandom), 5'($urandom), 9'($urandom));
  endtask

  task automatic random_request(output bit counted);
    int roll;
    roll = $urandom_range(0, 99);
    counted = 1'b1;
    if (roll < 6) begin
      send_item(KIND_UNUSED, 5'($urandom), 5'($urandom), 9'($urandom));
      counted = 1'b0;
    end else if (roll < 50) begin
      send_item(KIND_LOAD, pick_index(used_node_count()), pick_index(used_node_count()),
                random_weight());
    end else if (roll < 94) begin
      send_read_of_loaded(used_node_count());
    end else begin
      send_run();
    end
  endtask

  // index extremes, weight extremes, no-edge weights and the unused kind
  task automatic test_load_and_read();
    send_item(KIND_LOAD, 5'd0, 5'd0, 9'd0);
    send_item(KIND_LOAD, 5'd31, 5'd31, 9'd255);
    send_item(KIND_LOAD, 5'd0, 5'd31, NO_EDGE_WEIGHT);
    send_item(KIND_LOAD, 5'd31, 5'd0, 9'h100);
    send_item(KIND_LOAD, 5'd5, 5'd10, 9'h1AA);
    send_item(KIND_UNUSED, 5'd31, 5'd31, 9'h1FF);
    send_item(KIND_READ, 5'd0, 5'd0, 9'h1FF);
    send_item(KIND_READ, 5'd31, 5'd31, 9'd0);
    send_item(KIND_READ, 5'd0, 5'd31, 9'd0);
    send_item(KIND_READ, 5'd31, 5'd0, 9'd0);
    send_item(KIND_READ, 5'd5, 5'd10, 9'd0);
    drain();
  endtask

  task automatic test_closure_small();
    write_config(6'd2, 8'd1);
    send_item(KIND_LOAD, 5'd0, 5'd0, 9'd3);
    send_item(KIND_LOAD, 5'd0, 5'd1, NO_EDGE_WEIGHT);
    send_item(KIND_LOAD, 5'd1, 5'd0, 9'd7);
    send_item(KIND_LOAD, 5'd1, 5'd1, 9'd0);
    send_item(KIND_RUN, 5'd0, 5'd0, 9'd0);
    send_item(KIND_READ, 5'd0, 5'd0, 9'd0);
    send_item(KIND_READ, 5'd0, 5'd1, 9'd0);
    send_item(KIND_READ, 5'd1, 5'd0, 9'd0);
    send_item(KIND_READ, 5'd1, 5'd1, 9'd0);
    drain();
    // zero node count behaves as a single node
    write_config(6'd0, 8'd255);
    send_item(KIND_RUN, 5'd0, 5'd0, 9'd0);
    send_item(KIND_READ, 5'd0, 5'd0, 9'd0);
    drain();
  endtask

  // receiver holds off long enough for the output register to fill and stall requests
  task automatic test_output_backpressure();
    int i;
    hold_requests++;
    for (i = 0; i < 24; i++) send_read_of_loaded(NODES);
    drain();
  endtask

  task automatic test_random_traffic();
    int phase, sent;
    bit counted;
    logic [5:0] nodes;
    logic [7:0] weight_max;
    for (phase = 0; phase < 8; phase++) begin
      drain();
      if (phase == 0) begin
        nodes = 6'd1;
        weight_max = 8'd1;
      end else if (phase == 1) begin
        nodes = 6'd0;
        weight_max = 8'd255;
      end else begin
        nodes = 6'($urandom_range(2, 8));
        weight_max = 8'($urandom_range(1, 255));
      end
      write_config(nodes, weight_max);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_request(counted);
        if (counted) sent++;
      end
    end
    drain();
  endtask

  // full node count, then a node count above the maximum; loads and reads over the matrix
  task automatic test_full_size();
    int i;
    write_config(6'd32, 8'd255);
    send_item(KIND_LOAD, 5'd31, 5'd30, NO_EDGE_WEIGHT);
    send_item(KIND_READ, 5'd31, 5'd30, 9'd0);
    for (i = 0; i < 30; i++) send_item(KIND_LOAD, pick_index(NODES), pick_index(NODES),
                                       random_weight());
    for (i = 0; i < 30; i++) send_read_of_loaded(NODES);
    drain();
    write_config(6'd63, 8'($urandom_range(1, 255)));
    send_item(KIND_LOAD, 5'd30, 5'd31, NO_EDGE_WEIGHT);
    send_item(KIND_READ, 5'd30, 5'd31, 9'd0);
    for (i = 0; i < 10; i++) send_item(KIND_LOAD, pick_index(NODES), pick_index(NODES),
                                       random_weight());
    for (i = 0; i < 20; i++) send_read_of_loaded(NODES);
    drain();
  endtask

  // receiver: rotating stall pattern, redrawn at random, plus requested long holds
  initial begin : receiver
    int hold_served, step;
    logic [15:0] pattern;
    hold_served = 0;
    step = 0;
    pattern = '1;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_served++;
      end else begin
        if (step % 64 == 0) pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        out_tready <= pattern[step % 16];
        step++;
      end
    end
  end

  always @(posedge clk) begin : distance_check
    logic [DIST_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_distances.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result: distance %0d", out_tdata[DIST_W-1:0]);
        error_count <= error_count + 1;
      end else begin
        want = expected_distances.pop_front();
        if (out_tdata[DIST_W-1:0] !== want) begin
          if (error_count < MAX_REPORTS)
            $display("distance mismatch: expected %0d, got %0d", want,
                     out_tdata[DIST_W-1:0]);
          error_count <= error_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("all_pairs_shortest_path_unit regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_and_read();
    test_closure_small();
    test_output_backpressure();
    test_random_traffic();
    test_full_size();
    drain();
    if (error_count == 0 && expected_distances.size() == 0) begin
      $display("all_pairs_shortest_path_unit regression: pass");
    end else begin
      $display("all_pairs_shortest_path_unit regression: fail");
    end
    $finish;
  end

endmodule
